// ===== hdl/rfte_pkg.sv =====
`default_nettype none

package rfte_pkg;

	localparam int unsigned RECORD_COUNT_DEF = 12;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned QUOT_BITS = 31;
	localparam int unsigned CHANNELS  = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} fsm_state_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [31:0] end_rgba;
		logic [31:0] begin_rgba;
		logic [14:0] remaining;
		logic [14:0] duration;
	} slot_entry_t;

endpackage

`default_nettype wire

// ===== hdl/rgba_fade_table_engine.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// request   in         in_valid / in_stall     func, slot, handle, colours, counts
// result    out        out_valid / out_stall   out_handle, red..alpha, flags, last
//
// A load request writes its slot as it is accepted. A tick request scans the slots in
// order: a free slot is skipped, an expiring slot is read, checked and emitted, and a
// fading slot also passes the 31 steps of the shared restoring divider (skipped when its
// duration is zero) and four passes of one multiplier. The request side stalls meanwhile.
// Reset clears the active flags of all slots; the slot memory itself is not cleared.
// A stalled result holds the sequencer in its emit step until the register is free.

module rgba_fade_table_engine #(
	parameter int unsigned RECORD_COUNT = rfte_pkg::RECORD_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               func,
	input  wire logic        [3:0]  slot,
	input  wire logic signed [31:0] handle,
	input  wire logic        [31:0] end_rgba,
	input  wire logic        [31:0] begin_rgba,
	input  wire logic        [14:0] remaining,
	input  wire logic        [14:0] duration,
	input  wire logic        [14:0] tick_amount,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      out_handle,
	output logic        [7:0]       red,
	output logic        [7:0]       green,
	output logic        [7:0]       blue,
	output logic        [7:0]       alpha,
	output logic                    by_address,
	output logic                    expired,
	output logic                    last
);
	import rfte_pkg::*;

	localparam int unsigned IDX_W  = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
	localparam int unsigned SLOT_W = (IDX_W > 4) ? IDX_W : 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_COUNT - 1);

	fsm_state_t state_q, state_d;

	slot_entry_t mem [RECORD_COUNT];
	slot_entry_t rd_q;
	slot_entry_t mem_wdata;
	logic [IDX_W-1:0] mem_waddr;
	logic mem_we;
	logic mem_re;

	logic [RECORD_COUNT-1:0] active_q;
	logic [IDX_W-1:0] idx_q;
	logic [14:0] amount_q;
	logic [14:0] div_rem_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic [4:0] div_cnt_q;
	logic [1:0] ch_q;
	logic [31:0] col_q;
	logic expire_q;

	logic out_valid_q;
	logic [31:0] out_handle_q;
	logic [31:0] out_col_q;
	logic out_by_addr_q;
	logic out_expired_q;
	logic out_last_q;

	logic in_accept;
	logic out_free;
	logic [SLOT_W-1:0] slot_ext;
	logic load_ok;
	logic do_expire;
	logic [14:0] nrem;
	logic [15:0] div_trial;
	logic div_ge;
	logic [14:0] div_r;
	logic [7:0] e_byte;
	logic [7:0] b_byte;
	logic [8:0] diff9;
	logic [23:0] diff24;
	logic [23:0] prod;
	logic [7:0] chan;
	logic more_active;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign slot_ext = SLOT_W'(slot);
	assign load_ok  = (32'(slot) < RECORD_COUNT);

	assign do_expire = (amount_q >= rd_q.remaining);
	assign nrem      = rd_q.remaining - amount_q;

	assign div_trial = {div_rem_q, quot_q[QUOT_BITS-1]};
	assign div_ge    = (div_trial >= {1'b0, rd_q.duration});
	assign div_r     = div_ge ? 15'(div_trial - {1'b0, rd_q.duration}) : div_trial[14:0];

	assign e_byte = 8'(rd_q.end_rgba >> {~ch_q, 3'b000});
	assign b_byte = 8'(rd_q.begin_rgba >> {~ch_q, 3'b000});
	assign diff9  = {1'b0, b_byte} - {1'b0, e_byte};
	assign diff24 = {{15{diff9[8]}}, diff9};
	assign prod   = diff24 * quot_q[23:0];
	assign chan   = e_byte + prod[23:16];

	always_comb begin
		more_active = 1'b0;
		for (int i = 0; i < RECORD_COUNT; i++) begin
			if (active_q[i] && (i > 32'(idx_q))) begin
				more_active = 1'b1;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_q;
		mem_re    = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_waddr = slot_ext[IDX_W-1:0];
				mem_wdata.handle     = handle;
				mem_wdata.end_rgba   = end_rgba;
				mem_wdata.begin_rgba = begin_rgba;
				mem_wdata.remaining  = remaining;
				mem_wdata.duration   = duration;
				if (in_accept && !func) begin
					mem_we = load_ok;
				end
				if (in_accept && func) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (active_q[idx_q]) begin
					mem_re  = 1'b1;
					state_d = ST_CHECK;
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				mem_wdata.remaining = nrem;
				mem_we = !do_expire;
				if (do_expire) begin
					state_d = ST_EMIT;
				end else if (rd_q.duration == '0) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == 5'(QUOT_BITS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (ch_q == 2'(CHANNELS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			idx_q    <= '0;
		end else begin
			if (state_q == ST_IDLE && in_accept && !func && load_ok) begin
				active_q[slot_ext[IDX_W-1:0]] <= (handle != '0);
			end
			if (state_q == ST_CHECK && do_expire) begin
				active_q[idx_q] <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_SCAN && !active_q[idx_q] && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end else if (state_q == ST_EMIT && out_free && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			amount_q <= tick_amount;
		end
		unique case (state_q)
			ST_CHECK: begin
				expire_q  <= do_expire;
				col_q     <= rd_q.end_rgba;
				div_rem_q <= '0;
				div_cnt_q <= '0;
				ch_q      <= '0;
				quot_q    <= (rd_q.duration == '0) ? '0 : {nrem, {FRAC_BITS{1'b0}}};
			end
			ST_DIV: begin
				div_rem_q <= div_r;
				quot_q    <= {quot_q[QUOT_BITS-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			ST_MUL: begin
				col_q <= {col_q[23:0], chan};
				ch_q  <= ch_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_handle_q  <= rd_q.handle;
			out_col_q     <= col_q;
			out_by_addr_q <= !rd_q.handle[31];
			out_expired_q <= expire_q;
			out_last_q    <= !more_active;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_handle = out_handle_q;
	assign red        = out_col_q[31:24];
	assign green      = out_col_q[23:16];
	assign blue       = out_col_q[15:8];
	assign alpha      = out_col_q[7:0];
	assign by_address = out_by_addr_q;
	assign expired    = out_expired_q;
	assign last       = out_last_q;

endmodule

`default_nettype wire
